// ===== sv/bri_pkg.sv =====
// Package for the bilinear RGBA interpolation core.
// Holds field widths, register indexes and the lane control type.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package bri_pkg;

    localparam int COORD_W    = 12;
    localparam int FRAC_IN_W  = 16;
    localparam int PIX_W      = 32;
    localparam int DIM_W      = 13;
    localparam int LANES      = 4;
    localparam int LANE_W     = 8;
    localparam int CFG_IDX_W  = 1;

    localparam int DEF_MAX_DIM   = 4096;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic h_en;
        logic v_en;
        logic do_h;
        logic do_v;
    } t_lane_ctrl;

endpackage

// ===== sv/bri_in_if.sv =====
// Request channel of the core: one sample point and its four neighbours.
// Depends on bri_pkg for the field widths.
`timescale 1ns / 1ps

interface bri_in_if
    import bri_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   col_index;
    logic [COORD_W-1:0]   row_index;
    logic [FRAC_IN_W-1:0] frac_x;
    logic [FRAC_IN_W-1:0] frac_y;
    logic [PIX_W-1:0]     pixel_top_left;
    logic [PIX_W-1:0]     pixel_top_right;
    logic [PIX_W-1:0]     pixel_bottom_left;
    logic [PIX_W-1:0]     pixel_bottom_right;

    modport source (
        output valid, col_index, row_index, frac_x, frac_y,
               pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
        input  ready
    );
    modport sink (
        input  valid, col_index, row_index, frac_x, frac_y,
               pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right,
        output ready
    );
endinterface

// ===== sv/bri_out_if.sv =====
// Result channel of the core: one interpolated pixel per request.
// Depends on bri_pkg for the field width.
`timescale 1ns / 1ps

interface bri_out_if
    import bri_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink   (input valid, pixel_out, output ready);
endinterface

// ===== sv/bri_lane.sv =====
// One 8-bit byte lane: registered horizontal step, then registered vertical step.
// Depends on bri_pkg for the lane control struct.
`timescale 1ns / 1ps

module bri_lane
    import bri_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  t_lane_ctrl                   i_ctrl,
    input  logic [FRAC_BITS-1:0]         i_fx,
    input  logic [FRAC_BITS-1:0]         i_fy,
    input  logic [LANE_W-1:0]            i_tl,
    input  logic [LANE_W-1:0]            i_tr,
    input  logic [LANE_W-1:0]            i_bl,
    input  logic [LANE_W-1:0]            i_br,
    output logic [LANE_W+2*FRAC_BITS-1:0] o_v
);

    localparam int H_W  = LANE_W + FRAC_BITS;
    localparam int HP_W = H_W + 1;
    localparam int V_W  = LANE_W + 2 * FRAC_BITS;
    localparam int VP_W = V_W + 1;

    logic [FRAC_BITS:0] w_fx_inv;
    logic [FRAC_BITS:0] w_fy_inv;
    logic [HP_W-1:0]    w_top_full;
    logic [HP_W-1:0]    w_bot_full;
    logic [VP_W-1:0]    w_v_full;
    logic [H_W-1:0]     r_top, n_top;
    logic [H_W-1:0]     r_bot, n_bot;
    logic [V_W-1:0]     r_v, n_v;

    assign w_fx_inv = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, i_fx};
    assign w_fy_inv = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, i_fy};

    assign w_top_full = HP_W'(w_fx_inv) * HP_W'(i_tl) + HP_W'(i_fx) * HP_W'(i_tr);
    assign w_bot_full = HP_W'(w_fx_inv) * HP_W'(i_bl) + HP_W'(i_fx) * HP_W'(i_br);

    always_comb begin
        if (i_ctrl.do_h) begin
            n_top = w_top_full[H_W-1:0];
            n_bot = w_bot_full[H_W-1:0];
        end else begin
            n_top = {i_tl, {FRAC_BITS{1'b0}}};
            n_bot = {i_bl, {FRAC_BITS{1'b0}}};
        end
    end

    assign w_v_full = VP_W'(w_fy_inv) * VP_W'(r_top) + VP_W'(i_fy) * VP_W'(r_bot);

    // Without the vertical step the top value is scaled up so that the common
    // shift in the merging stage yields the horizontal result truncated.
    always_comb begin
        if (i_ctrl.do_v) begin
            n_v = w_v_full[V_W-1:0];
        end else begin
            n_v = {r_top, {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.h_en) begin
            r_top <= n_top;
            r_bot <= n_bot;
        end
        if (i_ctrl.v_en) begin
            r_v <= n_v;
        end
    end

    assign o_v = r_v;

endmodule

// ===== sv/bri_merge.sv =====
// Merging stage: scales each lane back to 8 bits, clamps, packs the pixel.
// Depends on bri_pkg for lane count and widths.
`timescale 1ns / 1ps

module bri_merge
    import bri_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic [LANES-1:0][LANE_W+2*FRAC_BITS-1:0] i_lane_v,
    output logic [PIX_W-1:0]                          o_pixel
);

    localparam int V_W = LANE_W + 2 * FRAC_BITS;

    logic [PIX_W-1:0] r_pixel, n_pixel;

    always_comb begin
        n_pixel = '0;
        for (int k = 0; k < LANES; k++) begin
            if (i_lane_v[k] > V_W'({{LANE_W{1'b1}}, {(2 * FRAC_BITS){1'b1}}})) begin
                n_pixel[k*LANE_W +: LANE_W] = {LANE_W{1'b1}};
            end else begin
                n_pixel[k*LANE_W +: LANE_W] = i_lane_v[k][V_W-1:2*FRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

// ===== sv/bilinear_rgba_interpolation_core.sv =====
// Top level of the bilinear RGBA8888 interpolation core.
// Depends on bri_pkg, bri_in_if, bri_out_if, bri_lane and bri_merge.
//
// Channel   Direction  Handshake     Payload
// i_in      in         valid/ready   coordinates, fractions, four pixels
// o_out     out        valid/ready   pixel_out
// i_cfg_*   in         write enable  register index and data
//
// One request per cycle is sustained while o_out.ready stays high.
// The four stages are input capture, horizontal multiply, vertical multiply and merge.
// Each stage holds its data while the stage after it is full and stalled.
// Synchronous active-low reset empties the pipeline and sets both dimensions to one.
`timescale 1ns / 1ps

module bilinear_rgba_interpolation_core
    import bri_pkg::*;
#(
    parameter int MAX_DIM   = DEF_MAX_DIM,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bri_in_if.sink               i_in,
    bri_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    localparam int MD_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W = ((DIM_W > MD_W) ? DIM_W : MD_W) + 1;
    localparam int V_W   = LANE_W + 2 * FRAC_BITS;

    logic [DIM_W-1:0]     r_image_width;
    logic [DIM_W-1:0]     r_image_height;
    logic [CMP_W-1:0]     w_eff_w;
    logic [CMP_W-1:0]     w_eff_h;
    logic                 w_do_h;
    logic                 w_do_v;

    logic                 r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;
    logic                 w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic                 r_s1_do_h, r_s1_do_v, r_s2_do_v;
    logic [FRAC_BITS-1:0] r_s1_fx, r_s1_fy, r_s2_fy;
    logic [PIX_W-1:0]     r_s1_tl, r_s1_tr, r_s1_bl, r_s1_br;

    t_lane_ctrl                         w_ctrl;
    logic [LANES-1:0][V_W-1:0]          w_lane_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(1);
            r_image_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff_w = (CMP_W'(r_image_width) > CMP_W'(MAX_DIM)) ?
                     CMP_W'(MAX_DIM) : CMP_W'(r_image_width);
    assign w_eff_h = (CMP_W'(r_image_height) > CMP_W'(MAX_DIM)) ?
                     CMP_W'(MAX_DIM) : CMP_W'(r_image_height);
    assign w_do_h  = (CMP_W'(i_in.col_index) + CMP_W'(1)) < w_eff_w;
    assign w_do_v  = (CMP_W'(i_in.row_index) + CMP_W'(1)) < w_eff_h;

    assign w_rdy4 = !r_out_vld || o_out.ready;
    assign w_rdy3 = !r_s3_vld || w_rdy4;
    assign w_rdy2 = !r_s2_vld || w_rdy3;
    assign w_rdy1 = !r_s1_vld || w_rdy2;
    assign i_in.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_rdy1) r_s1_vld  <= i_in.valid;
            if (w_rdy2) r_s2_vld  <= r_s1_vld;
            if (w_rdy3) r_s3_vld  <= r_s2_vld;
            if (w_rdy4) r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_do_h <= w_do_h;
            r_s1_do_v <= w_do_v;
            r_s1_fx   <= FRAC_BITS'(i_in.frac_x);
            r_s1_fy   <= FRAC_BITS'(i_in.frac_y);
            r_s1_tl   <= i_in.pixel_top_left;
            r_s1_tr   <= i_in.pixel_top_right;
            r_s1_bl   <= i_in.pixel_bottom_left;
            r_s1_br   <= i_in.pixel_bottom_right;
        end
        if (w_rdy2) begin
            r_s2_do_v <= r_s1_do_v;
            r_s2_fy   <= r_s1_fy;
        end
    end

    assign w_ctrl.h_en = w_rdy2;
    assign w_ctrl.v_en = w_rdy3;
    assign w_ctrl.do_h = r_s1_do_h;
    assign w_ctrl.do_v = r_s2_do_v;

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        bri_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_fx   (r_s1_fx),
            .i_fy   (r_s2_fy),
            .i_tl   (r_s1_tl[k*LANE_W +: LANE_W]),
            .i_tr   (r_s1_tr[k*LANE_W +: LANE_W]),
            .i_bl   (r_s1_bl[k*LANE_W +: LANE_W]),
            .i_br   (r_s1_br[k*LANE_W +: LANE_W]),
            .o_v    (w_lane_v[k])
        );
    end

    bri_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (w_rdy4),
        .i_lane_v (w_lane_v),
        .o_pixel  (o_out.pixel_out)
    );

    assign o_out.valid = r_out_vld;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s1_vld)
        else $error("accepted request did not reach the first stage");

    a_s3_moves_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && w_rdy4) |=> r_out_vld)
        else $error("vertical stage result was lost on its way to the output");

    a_empty_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_vld && !r_s2_vld) |-> i_in.ready)
        else $error("request refused while the front of the pipeline is empty");

endmodule

// ===== tb/tb_bilinear_rgba_interpolation_core.sv =====
// Self-checking testbench for the bilinear RGBA8888 interpolation core.
// Drives sample requests and dimension writes, predicts every output pixel and checks it.
// Depends on bri_pkg, bri_in_if, bri_out_if and bilinear_rgba_interpolation_core.
`timescale 1ns / 1ps

module tb_bilinear_rgba_interpolation_core;
    import bri_pkg::*;

    localparam int          CYCLE_LIMIT = 300000;
    localparam int          HOLD_AT     = 150;
    localparam int          HOLD_LEN    = 400;
    localparam logic [63:0] FRAC_ONE    = 64'd1 << DEF_FRAC_BITS;

    typedef struct {
        logic [COORD_W-1:0]   col_index;
        logic [COORD_W-1:0]   row_index;
        logic [FRAC_IN_W-1:0] frac_x;
        logic [FRAC_IN_W-1:0] frac_y;
        logic [PIX_W-1:0]     top_left;
        logic [PIX_W-1:0]     top_right;
        logic [PIX_W-1:0]     bottom_left;
        logic [PIX_W-1:0]     bottom_right;
    } t_sample;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_reg         i_cfg_idx;
    logic [DIM_W-1:0] i_cfg_data;

    bri_in_if  in_if ();
    bri_out_if out_if ();

    bilinear_rgba_interpolation_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_sample          sample_queue[$];
    logic [PIX_W-1:0] pending_pixels[$];
    t_sample          sample_on_bus;
    logic [DIM_W-1:0] dim_width;
    logic [DIM_W-1:0] dim_height;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               fail_count;
    int               results_seen;
    int               long_hold_left;
    bit               hold_done;
    int               cycle_count;

    function automatic int effective_dim(logic [DIM_W-1:0] dim);
        return (int'(dim) > DEF_MAX_DIM) ? DEF_MAX_DIM : int'(dim);
    endfunction

    function automatic logic [PIX_W-1:0] interpolate_pixel(t_sample s);
        bit               span_h;
        bit               span_v;
        logic [63:0]      top;
        logic [63:0]      bot;
        logic [63:0]      lane;
        logic [PIX_W-1:0] pix;
        span_h = (int'(s.col_index) + 1) < effective_dim(dim_width);
        span_v = (int'(s.row_index) + 1) < effective_dim(dim_height);
        pix = '0;
        for (int k = 0; k < LANES; k++) begin
            if (span_h) begin
                top = (FRAC_ONE - s.frac_x) * s.top_left[LANE_W*k +: LANE_W]
                    + s.frac_x * s.top_right[LANE_W*k +: LANE_W];
                bot = (FRAC_ONE - s.frac_x) * s.bottom_left[LANE_W*k +: LANE_W]
                    + s.frac_x * s.bottom_right[LANE_W*k +: LANE_W];
            end else begin
                top = 64'(s.top_left[LANE_W*k +: LANE_W]) << DEF_FRAC_BITS;
                bot = 64'(s.bottom_left[LANE_W*k +: LANE_W]) << DEF_FRAC_BITS;
            end
            if (span_v) begin
                lane = ((FRAC_ONE - s.frac_y) * top + s.frac_y * bot) >> (2 * DEF_FRAC_BITS);
            end else begin
                lane = top >> DEF_FRAC_BITS;
            end
            if (lane > 64'd255) begin
                lane = 64'd255;
            end
            pix[LANE_W*k +: LANE_W] = lane[LANE_W-1:0];
        end
        return pix;
    endfunction

    function automatic t_sample make_sample(int col, int row, int fx, int fy,
                                            logic [31:0] tl, logic [31:0] tr,
                                            logic [31:0] bl, logic [31:0] br);
        t_sample s;
        s.col_index    = col[COORD_W-1:0];
        s.row_index    = row[COORD_W-1:0];
        s.frac_x       = fx[FRAC_IN_W-1:0];
        s.frac_y       = fy[FRAC_IN_W-1:0];
        s.top_left     = tl;
        s.top_right    = tr;
        s.bottom_left  = bl;
        s.bottom_right = br;
        return s;
    endfunction

    function automatic int random_coord(logic [DIM_W-1:0] dim);
        int eff;
        int c;
        eff = effective_dim(dim);
        case ($urandom_range(3))
            0: c = $urandom_range(4095);
            1: c = eff - 2 + $urandom_range(3);
            2: c = $urandom_range(3);
            default: c = (eff > 1) ? $urandom_range(eff - 1) : 0;
        endcase
        if (c < 0) c = 0;
        if (c > 4095) c = 4095;
        return c;
    endfunction

    function automatic int random_frac();
        case ($urandom_range(7))
            0: return 0;
            1: return 16'hFFFF;
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    function automatic logic [31:0] random_pixel();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            sample_queue.push_back(make_sample(random_coord(dim_width), random_coord(dim_height),
                random_frac(), random_frac(), random_pixel(), random_pixel(),
                random_pixel(), random_pixel()));
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (sample_queue.size() != 0 || in_if.valid || pending_pixels.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_IMAGE_WIDTH;
        i_cfg_data <= w;
        dim_width = w;
        @(posedge i_clk);
        i_cfg_idx  <= REG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        dim_height = h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_pressure(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL bilinear_rgba_interpolation_core");
            $finish;
        end
    end

    always @(posedge i_clk) begin : driver
        t_sample nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                pending_pixels.push_back(interpolate_pixel(sample_on_bus));
            end
            if (!in_if.valid || in_if.ready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = sample_queue.pop_front();
                    sample_on_bus                <= nxt;
                    in_if.col_index              <= nxt.col_index;
                    in_if.row_index              <= nxt.row_index;
                    in_if.frac_x                 <= nxt.frac_x;
                    in_if.frac_y                 <= nxt.frac_y;
                    in_if.pixel_top_left         <= nxt.top_left;
                    in_if.pixel_top_right        <= nxt.top_right;
                    in_if.pixel_bottom_left      <= nxt.bottom_left;
                    in_if.pixel_bottom_right     <= nxt.bottom_right;
                    in_if.valid                  <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        bit take;
        take = 1'b0;
        if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
        end else if (results_seen == HOLD_AT && !hold_done) begin
            long_hold_left <= HOLD_LEN;
            hold_done      <= 1'b1;
        end else begin
            take = ($urandom_range(99) >= recv_stall_pct);
        end
        out_if.ready <= take;
    end

    always @(posedge i_clk) begin : monitor
        logic [PIX_W-1:0] want_pixel;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen <= results_seen + 1;
            if (pending_pixels.size() == 0) begin
                $error("pixel_out arrived with no request pending: actual %08h",
                       out_if.pixel_out);
                fail_count++;
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (out_if.pixel_out !== want_pixel) begin
                    $error("pixel_out mismatch: expected %08h, actual %08h",
                           want_pixel, out_if.pixel_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_idx                = REG_IMAGE_WIDTH;
        i_cfg_data               = '0;
        in_if.valid              = 1'b0;
        in_if.col_index          = '0;
        in_if.row_index          = '0;
        in_if.frac_x             = '0;
        in_if.frac_y             = '0;
        in_if.pixel_top_left     = '0;
        in_if.pixel_top_right    = '0;
        in_if.pixel_bottom_left  = '0;
        in_if.pixel_bottom_right = '0;
        out_if.ready             = 1'b0;
        dim_width                = 13'd1;
        dim_height               = 13'd1;
        fail_count               = 0;
        results_seen             = 0;
        cycle_count              = 0;
        set_pressure(0, 0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset dimensions every sample sits on the last column and row.
        sample_queue.push_back(make_sample(0, 0, 16'hFFFF, 16'hFFFF,
            32'h00FF_7F80, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        sample_queue.push_back(make_sample(4095, 4095, 16'h8000, 16'h1234,
            32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        sample_queue.push_back(make_sample(1, 0, 0, 0,
            32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210));
        wait_drained();

        write_dims(13'd4096, 13'd4096);
        sample_queue.push_back(make_sample(0, 0, 0, 0,
            32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        sample_queue.push_back(make_sample(0, 0, 16'hFFFF, 0,
            32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA));
        sample_queue.push_back(make_sample(0, 0, 0, 16'hFFFF,
            32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000));
        sample_queue.push_back(make_sample(10, 20, 16'hFFFF, 16'hFFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        sample_queue.push_back(make_sample(10, 20, 16'h8000, 16'h8000,
            32'h00FF_00FF, 32'hFF00_FF00, 32'hFF00_00FF, 32'h00FF_FF00));
        sample_queue.push_back(make_sample(10, 20, 16'h1234, 16'hFEDC,
            32'h0, 32'h0, 32'h0, 32'h0));
        sample_queue.push_back(make_sample(4094, 4094, 16'hC000, 16'h4000,
            32'h8040_2010, 32'h0102_0408, 32'hF0E0_D0C0, 32'h1F2F_3F4F));
        sample_queue.push_back(make_sample(4095, 100, 16'h8000, 16'h8000,
            32'h8040_2010, 32'hFFFF_FFFF, 32'h1020_4080, 32'hFFFF_FFFF));
        sample_queue.push_back(make_sample(100, 4095, 16'h8000, 16'h8000,
            32'h8040_2010, 32'h1020_4080, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        sample_queue.push_back(make_sample(4095, 4095, 16'hFFFF, 16'hFFFF,
            32'hA5A5_5A5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        sample_queue.push_back(make_sample(12'hAAA, 12'h555, 16'hAAAA, 16'h5555,
            32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA));
        sample_queue.push_back(make_sample(12'h555, 12'hAAA, 16'h5555, 16'hAAAA,
            32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));
        queue_random(500);
        wait_drained();

        // Oversized width acts as the maximum; zero height makes every row the last.
        write_dims(13'd8191, 13'd0);
        set_pressure(77, 0);
        queue_random(400);
        wait_drained();

        write_dims(13'd0, 13'd8191);
        set_pressure(0, 77);
        queue_random(400);
        wait_drained();

        set_pressure(19, 19);
        for (int p = 0; p < 4; p++) begin
            write_dims(13'($urandom_range(1, 20)), 13'($urandom_range(1, 20)));
            queue_random(100);
            wait_drained();
        end

        write_dims(13'd4097, 13'd1);
        set_pressure(0, 0);
        queue_random(150);
        wait_drained();

        write_dims(13'd2, 13'd4097);
        queue_random(150);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $error("%0d pixel_out results never arrived", pending_pixels.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("PASS bilinear_rgba_interpolation_core");
        end else begin
            $display("FAIL bilinear_rgba_interpolation_core");
        end
        $finish;
    end

endmodule
